/* design/aef_pkg.sv */
// Shared types and constants of the AX.25 echo filter.
// No dependencies; every other design file depends on this package.
`default_nettype none
package aef_pkg;

   // Sizes of the filter.
   localparam int MAX_CALLS = 7;
   localparam int MAX_DIGIS = 8;
   localparam int ADDR_LEN  = 7;

   // Field widths.
   localparam int BYTE_W   = 8;
   localparam int ADDR_W   = ADDR_LEN * BYTE_W;
   localparam int BIA_W    = 3;
   localparam int ANUM_W   = 4;
   localparam int CSR_IDX_W = 3;
   localparam int COUNT_W  = 3;

   // Address byte bits and masks.
   localparam logic [BYTE_W-1:0] KISS_CMD_MASK = 8'h0F;
   localparam int SSID_REPEATED_BIT = 7;
   localparam int SSID_EXT_BIT      = 0;
   localparam logic [ADDR_W-1:0] CMP_MASK = 56'hFE_FEFE_FEFE_FE1E;
   localparam logic [ANUM_W-1:0] ANUM_MAX = 4'd15;
   localparam logic [ANUM_W-1:0] ANUM_DEST = 4'd0;
   localparam logic [ANUM_W-1:0] ANUM_SRC  = 4'd1;
   // The digipeater at position MAX_DIGIS sits at address number MAX_DIGIS + 1.
   localparam logic [ANUM_W-1:0] ANUM_LAST_DIGI = ANUM_W'(MAX_DIGIS + 1);
   localparam logic [BIA_W-1:0] BIA_SSID = BIA_W'(ADDR_LEN - 1);

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CALL_COUNT = 3'd7;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [MAX_CALLS-1:0][ADDR_W-1:0] call_list_type;

   typedef enum logic [1:0] {
      VERDICT_ECHO      = 2'd0,
      VERDICT_NOT_DATA  = 2'd1,
      VERDICT_MALFORMED = 2'd2,
      VERDICT_NO_MATCH  = 2'd3
   } verdict_type;

   // Header state as it stands after the current byte.
   typedef struct packed {
      logic     not_data;
      logic     header_done;
      logic     header_bad;
      logic     want_next_digi;
      addr_type chosen;
      addr_type dest;
   } parse_type;

endpackage
`default_nettype wire

/* design/aef_channels.sv */
// Valid/ready channel interfaces of the AX.25 echo filter.
// Depends on aef_pkg for field widths.
`default_nettype none
interface aef_req_if;
   logic                      valid;
   logic                      ready;
   logic [aef_pkg::BYTE_W-1:0] frame_byte;
   logic                      end_of_frame;
   modport source (output valid, output frame_byte, output end_of_frame, input ready);
   modport sink (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

interface aef_rsp_if;
   logic       valid;
   logic       ready;
   logic       echo;
   logic [1:0] verdict;
   modport source (output valid, output echo, output verdict, input ready);
   modport sink (input valid, input echo, input verdict, output ready);
endinterface

interface aef_csr_if;
   logic                         valid;
   logic                         ready;
   logic [aef_pkg::CSR_IDX_W-1:0] index;
   logic [aef_pkg::ADDR_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* design/aef_csr.sv */
// Configuration registers: seven callsigns and the call count.
// Depends on aef_pkg and the aef_csr_if interface.
`default_nettype none
module aef_csr (
   input  wire logic           clock,
   input  wire logic           reset,
   aef_csr_if.sink             csr_ch,
   output aef_pkg::call_list_type calls,
   output logic [aef_pkg::COUNT_W-1:0] call_count
);
   import aef_pkg::*;

   call_list_type        calls_ff;
   logic [COUNT_W-1:0]   count_ff;

   assign csr_ch.ready = 1'b1;

   // Write decode; the index space holds exactly the eight registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         calls_ff <= '0;
         count_ff <= '0;
      end else if (csr_ch.valid) begin
         if (csr_ch.index == CSR_CALL_COUNT) begin
            count_ff <= csr_ch.data[COUNT_W-1:0];
         end else begin
            calls_ff[csr_ch.index] <= csr_ch.data;
         end
      end
   end

   assign calls      = calls_ff;
   assign call_count = count_ff;

endmodule
`default_nettype wire

/* design/aef_parse.sv */
// Per-byte AX.25 address header parser with its frame state registers.
// Depends on aef_pkg.
`default_nettype none
module aef_parse (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step,
   input  wire logic [aef_pkg::BYTE_W-1:0] frame_byte,
   input  wire logic                      end_of_frame,
   output aef_pkg::parse_type             hdr
);
   import aef_pkg::*;

   logic               at_start_ff, at_start_in;
   logic [BIA_W-1:0]   bia_ff, bia_in;
   logic [ANUM_W-1:0]  anum_ff, anum_in;
   addr_type           shift_ff, shift_in;
   parse_type          hdr_ff, hdr_in;
   addr_type           shifted;

   assign shifted = {shift_ff[ADDR_W-BYTE_W-1:0], frame_byte};

   // Next header state for the current byte.
   always_comb begin
      hdr_in      = hdr_ff;
      bia_in      = bia_ff;
      anum_in     = anum_ff;
      shift_in    = shift_ff;
      at_start_in = end_of_frame;
      if (at_start_ff) begin
         // KISS type byte: fresh frame.
         hdr_in.not_data       = |(frame_byte & KISS_CMD_MASK);
         hdr_in.header_done    = 1'b0;
         hdr_in.header_bad     = 1'b0;
         hdr_in.want_next_digi = 1'b1;
         hdr_in.chosen         = '0;
         hdr_in.dest           = '0;
         bia_in                = '0;
         anum_in               = '0;
         shift_in              = '0;
      end else if (!(hdr_ff.header_done || hdr_ff.header_bad)) begin
         if (bia_ff != BIA_SSID) begin
            bia_in   = bia_ff + 1'b1;
            shift_in = shifted;
         end else begin
            // SSID byte closes an address.
            bia_in   = '0;
            shift_in = '0;
            if (anum_ff == ANUM_DEST) begin
               hdr_in.dest = shifted;
            end else if (anum_ff == ANUM_SRC) begin
               if (frame_byte[SSID_EXT_BIT]) begin
                  hdr_in.header_done = 1'b1;
               end
            end else begin
               if (frame_byte[SSID_REPEATED_BIT]) begin
                  hdr_in.want_next_digi = 1'b1;
               end else if (hdr_ff.want_next_digi) begin
                  hdr_in.chosen         = shifted;
                  hdr_in.want_next_digi = 1'b0;
               end
               if (frame_byte[SSID_EXT_BIT]) begin
                  hdr_in.header_done = 1'b1;
               end else if (anum_ff >= ANUM_LAST_DIGI) begin
                  hdr_in.header_bad = 1'b1;
               end
            end
            if (anum_ff != ANUM_MAX) begin
               anum_in = anum_ff + 1'b1;
            end
         end
      end
   end

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
         bia_ff      <= '0;
         anum_ff     <= '0;
         shift_ff    <= '0;
         hdr_ff      <= '{not_data: 1'b0, header_done: 1'b0, header_bad: 1'b0,
                          want_next_digi: 1'b1, chosen: '0, dest: '0};
      end else if (step) begin
         at_start_ff <= at_start_in;
         bia_ff      <= bia_in;
         anum_ff     <= anum_in;
         shift_ff    <= shift_in;
         hdr_ff      <= hdr_in;
      end
   end

   assign hdr = hdr_in;

endmodule
`default_nettype wire

/* design/aef_match.sv */
// Verdict logic: picks the target address and compares it to the call list.
// Depends on aef_pkg.
`default_nettype none
module aef_match (
   input  wire aef_pkg::parse_type        hdr,
   input  wire aef_pkg::call_list_type    calls,
   input  wire logic [aef_pkg::COUNT_W-1:0] call_count,
   output aef_pkg::verdict_type           verdict
);
   import aef_pkg::*;

   addr_type             target;
   logic [MAX_CALLS-1:0] hit;

   assign target = hdr.want_next_digi ? hdr.dest : hdr.chosen;

   // One masked compare per configured call.
   always_comb begin
      for (int i = 0; i < MAX_CALLS; i++) begin
         hit[i] = (COUNT_W'(i) < call_count) &&
                  (((calls[i] ^ target) & CMP_MASK) == '0);
      end
   end

   always_comb begin
      priority if (hdr.not_data) begin
         verdict = VERDICT_NOT_DATA;
      end else if (call_count == '0) begin
         verdict = VERDICT_ECHO;
      end else if (hdr.header_bad || !hdr.header_done) begin
         verdict = VERDICT_MALFORMED;
      end else if (|hit) begin
         verdict = VERDICT_ECHO;
      end else begin
         verdict = VERDICT_NO_MATCH;
      end
   end

endmodule
`default_nettype wire

/* design/ax25_echo_filter_unit.sv */
// AX.25 echo filter top level: input register, parser, matcher, result register.
// The verdict is registered as the frame's last byte leaves the input register.
// Throughput: one byte per cycle unless a last byte waits for a full result slot;
// parser state and seven-way compare settle between the input and result registers.
// Reset (synchronous, active high) clears calls, call count and frame state.
// Depends on aef_pkg, the channel interfaces, aef_csr, aef_parse and aef_match.
`default_nettype none
module ax25_echo_filter_unit (
   input  wire logic clock,
   input  wire logic reset,
   aef_req_if.sink   req_ch,
   aef_rsp_if.source rsp_ch,
   aef_csr_if.sink   csr_ch
);
   import aef_pkg::*;

   logic               s1_valid_ff;
   logic [BYTE_W-1:0]  s1_byte_ff;
   logic               s1_eof_ff;
   logic               out_valid_ff;
   logic               out_echo_ff;
   verdict_type        out_verdict_ff;

   logic               out_free;
   logic               s1_go;
   call_list_type      calls;
   logic [COUNT_W-1:0] call_count;
   parse_type          hdr;
   verdict_type        verdict;

   // Handshake: a byte leaves the input register unless it needs a full result slot.
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign s1_go        = s1_valid_ff && (!s1_eof_ff || out_free);
   assign req_ch.ready = !s1_valid_ff || s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         s1_byte_ff <= req_ch.frame_byte;
         s1_eof_ff  <= req_ch.end_of_frame;
      end
   end

   aef_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_ch     (csr_ch),
      .calls      (calls),
      .call_count (call_count)
   );

   aef_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .step         (s1_go),
      .frame_byte   (s1_byte_ff),
      .end_of_frame (s1_eof_ff),
      .hdr          (hdr)
   );

   aef_match u_match (
      .hdr        (hdr),
      .calls      (calls),
      .call_count (call_count),
      .verdict    (verdict)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_go && s1_eof_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_eof_ff) begin
         out_echo_ff    <= (verdict == VERDICT_ECHO);
         out_verdict_ff <= verdict;
      end
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.echo    = out_echo_ff;
   assign rsp_ch.verdict = out_verdict_ff;

   // Echo flag agrees with the verdict code.
   a_echo_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_echo_ff == (out_verdict_ff == VERDICT_ECHO)))
      else $error("echo flag disagrees with verdict");

   // A new result only comes from a frame's last byte.
   a_result_src: assert property (@(posedge clock) disable iff (reset)
      (!out_valid_ff || rsp_ch.ready) && !(s1_go && s1_eof_ff) |=> !out_valid_ff)
      else $error("result without a last byte");

   // A held input item is never overwritten.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_go |=> s1_valid_ff && $stable(s1_byte_ff) && $stable(s1_eof_ff))
      else $error("input register overwritten");

   // A waiting result is never overwritten by a new one.
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready |-> !(s1_go && s1_eof_ff))
      else $error("result register overwritten");

endmodule
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Testbench for ax25_echo_filter_unit: streams KISS frames byte by byte, predicts each
// frame verdict with its own header parser and checks every verdict in order.
// Depends on aef_pkg, the channel interfaces and the design top level.
module testbench;
   import aef_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 11;
   localparam int IDLE_LIMIT   = 5000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_BYTES = 560;
   localparam int FRAMES_PER_SETTING = 10;

   // Compare mask: callsign bytes without bit 0, SSID bits 1 to 4 only.
   localparam addr_type MATCH_MASK = 56'hFE_FEFE_FEFE_FE1E;
   localparam addr_type ALL_ONES   = '1;
   localparam logic [BYTE_W-1:0] KISS_LOW_NIBBLE = 8'h0F;

   typedef struct {
      logic        echo;
      verdict_type verdict;
   } verdict_item;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #HALF_PERIOD clock = ~clock;

   aef_req_if req_ch();
   aef_rsp_if rsp_ch();
   aef_csr_if csr_ch();

   ax25_echo_filter_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Expected verdicts, oldest first.
   verdict_item verdict_queue[$];
   int          fail_count = 0;
   int          bytes_sent = 0;
   int          quiet_cycles = 0;

   // Idling controls shared with the receiver.
   bit send_idle = 1'b1;
   bit recv_idle = 1'b1;
   int stall_left = 0;
   int hold_left = 0;

   // Frame under construction and call list for the next configuration.
   logic [BYTE_W-1:0] frame_q[$];
   addr_type          call_plan[MAX_CALLS];

   // Filter state kept by the predictor.
   addr_type          calls_cfg[MAX_CALLS];
   logic [COUNT_W-1:0] count_cfg;
   bit                at_start;
   bit                nondata;
   logic [BIA_W-1:0]  byte_pos;
   logic [ANUM_W-1:0] addr_idx;
   addr_type          shift_reg;
   addr_type          chosen_addr;
   addr_type          dest_addr;
   bit                want_digi;
   bit                hdr_done;
   bit                hdr_bad;

   // ---------------------------------------------------------------- predictor

   function automatic void clear_frame_state();
      nondata     = 1'b0;
      byte_pos    = '0;
      addr_idx    = '0;
      shift_reg   = '0;
      chosen_addr = '0;
      dest_addr   = '0;
      want_digi   = 1'b1;
      hdr_done    = 1'b0;
      hdr_bad     = 1'b0;
   endfunction

   function automatic void reset_filter_state();
      foreach (calls_cfg[i]) calls_cfg[i] = '0;
      count_cfg = '0;
      clear_frame_state();
      at_start = 1'b1;
   endfunction

   // Header parser: one address byte at a time, frozen once done or bad.
   function automatic void parse_header_byte(input logic [BYTE_W-1:0] b);
      if (hdr_done || hdr_bad) return;
      shift_reg = {shift_reg[ADDR_W-BYTE_W-1:0], b};
      if (byte_pos < ADDR_LEN - 1) begin
         byte_pos++;
         return;
      end
      // b is the SSID byte of a full address
      byte_pos = '0;
      if (addr_idx == ANUM_DEST) begin
         dest_addr = shift_reg;
      end else if (addr_idx == ANUM_SRC) begin
         if (b[SSID_EXT_BIT]) hdr_done = 1'b1;
      end else begin
         if (b[SSID_REPEATED_BIT]) begin
            want_digi = 1'b1;
         end else if (want_digi) begin
            chosen_addr = shift_reg;
            want_digi   = 1'b0;
         end
         if (b[SSID_EXT_BIT]) hdr_done = 1'b1;
         else if (int'(addr_idx) - 1 >= MAX_DIGIS) hdr_bad = 1'b1;
      end
      shift_reg = '0;
      if (addr_idx != ANUM_MAX) addr_idx++;
   endfunction

   function automatic verdict_type frame_verdict();
      addr_type target;
      if (nondata) return VERDICT_NOT_DATA;
      if (count_cfg == 0) return VERDICT_ECHO;
      if (hdr_bad || !hdr_done) return VERDICT_MALFORMED;
      target = want_digi ? dest_addr : chosen_addr;
      for (int i = 0; i < int'(count_cfg) && i < MAX_CALLS; i++)
         if (((calls_cfg[i] ^ target) & MATCH_MASK) == '0) return VERDICT_ECHO;
      return VERDICT_NO_MATCH;
   endfunction

   // Called for each accepted byte; queues a verdict on the last byte of a frame.
   function automatic void predict_frame_byte(input logic [BYTE_W-1:0] b, input logic eof);
      verdict_type v;
      if (at_start) begin
         clear_frame_state();
         nondata = (b & KISS_LOW_NIBBLE) != '0;
      end else begin
         parse_header_byte(b);
      end
      if (!eof) begin
         at_start = 1'b0;
      end else begin
         at_start = 1'b1;
         v = frame_verdict();
         verdict_queue.push_back('{echo: (v == VERDICT_ECHO), verdict: v});
      end
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eof);
      int gap;
      gap = send_idle ? $urandom_range(0, 3) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.frame_byte   <= b;
      req_ch.end_of_frame <= eof;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predict_frame_byte(b, eof);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
   endtask

   // Stop offering bytes and let every verdict drain out.
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (verdict_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input addr_type data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      if (idx == CSR_CALL_COUNT) count_cfg = data[COUNT_W-1:0];
      else calls_cfg[idx] = data;
   endtask

   // Writes call_plan and the call count; upper count bits carry junk to check masking.
   task automatic apply_config(input logic [COUNT_W-1:0] count);
      addr_type junk;
      wait_idle();
      for (int i = 0; i < MAX_CALLS; i++) csr_write(CSR_IDX_W'(i), call_plan[i]);
      junk = random_address_bits();
      csr_write(CSR_CALL_COUNT, {junk[ADDR_W-1:COUNT_W], count});
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- frame building

   function automatic addr_type random_address_bits();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[ADDR_W-1:0];
   endfunction

   function automatic void fill_random_calls();
      foreach (call_plan[i]) begin
         case ($urandom_range(0, 7))
            0: call_plan[i] = ALL_ONES;
            1: call_plan[i] = '0;
            default: call_plan[i] = random_address_bits();
         endcase
      end
   endfunction

   // Mostly a configured call with the ignored bits scrambled, sometimes anything.
   function automatic addr_type random_address();
      if ($urandom_range(0, 3) != 0)
         return calls_cfg[$urandom_range(0, MAX_CALLS - 1)] ^
                (random_address_bits() & ~MATCH_MASK);
      return random_address_bits();
   endfunction

   function automatic void push_address(input addr_type a, input logic ext, input logic rep);
      addr_type v;
      v = a;
      v[SSID_REPEATED_BIT] = rep;
      v[SSID_EXT_BIT]      = ext;
      for (int k = ADDR_LEN - 1; k >= 0; k--) frame_q.push_back(v[k*BYTE_W +: BYTE_W]);
   endfunction

   // Header with n_digis digipeaters, a leading run of them marked repeated.
   function automatic void build_frame(input int n_digis, input bit kiss_cmd,
                                       input bit cut, input int payload);
      logic [BYTE_W-1:0] kiss;
      int rep_upto;
      int keep;
      frame_q.delete();
      kiss = BYTE_W'($urandom);
      if (!kiss_cmd) kiss[3:0] = '0;
      else if (kiss[3:0] == '0) kiss[0] = 1'b1;
      frame_q.push_back(kiss);
      push_address(random_address(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      push_address(random_address(), n_digis == 0, 1'($urandom_range(0, 1)));
      rep_upto = $urandom_range(0, n_digis);
      for (int i = 0; i < n_digis; i++)
         push_address(random_address(), i == n_digis - 1,
                      (i < rep_upto) || ($urandom_range(0, 3) == 0));
      if (cut) begin
         keep = $urandom_range(1, frame_q.size() - 1);
         frame_q = frame_q[0:keep-1];
      end else begin
         repeat (payload) frame_q.push_back(BYTE_W'($urandom));
      end
   endfunction

   function automatic void build_noise_frame(input int len);
      frame_q.delete();
      repeat (len) frame_q.push_back(BYTE_W'($urandom));
   endfunction

   // ---------------------------------------------------------------- tests

   // Reset settings: empty call list, so data frames echo and command frames do not.
   task automatic test_reset_defaults();
      frame_q = '{8'h00};
      send_frame();
      frame_q = '{8'h0F};
      send_frame();
      frame_q = '{8'hFF, 8'h00, 8'hFF};
      send_frame();
      frame_q = '{8'hF0, 8'hFF};
      send_frame();
   endtask

   // Extreme calls, one-byte frame, match on destination, truncated header.
   task automatic test_directed();
      call_plan[0] = ALL_ONES;
      call_plan[1] = '0;
      for (int i = 2; i < MAX_CALLS; i++) call_plan[i] = random_address_bits();
      apply_config(3'd7);
      // lone KISS byte has no header
      frame_q = '{8'h00};
      send_frame();
      // destination equal to the all-ones call apart from ignored bits
      frame_q.delete();
      frame_q.push_back(8'hF0);
      push_address(ALL_ONES ^ (random_address_bits() & ~MATCH_MASK), 1'b0, 1'b1);
      push_address('0, 1'b1, 1'b0);
      send_frame();
      // header cut off inside the destination
      frame_q = '{8'h00, 8'hFF, 8'hFE, 8'h00, 8'h01, 8'h80};
      send_frame();
   endtask

   // Every digipeater count up to beyond the limit, with bytes after the header.
   task automatic test_digipeaters();
      for (int pass = 0; pass < 2; pass++) begin
         fill_random_calls();
         apply_config(pass == 0 ? 3'd7 : 3'd1);
         for (int n = 0; n <= MAX_DIGIS + 2; n++) begin
            build_frame(n, 1'b0, 1'b0, $urandom_range(0, 4));
            send_frame();
         end
      end
   endtask

   // Receiver holds off while short frames keep coming, so the block backs up.
   task automatic test_pressure();
      send_idle = 1'b0;
      hold_left = HOLD_CYCLES;
      repeat (60) begin
         build_noise_frame(1);
         send_frame();
      end
      send_idle = 1'b1;
   endtask

   task automatic test_random();
      int start;
      int frames;
      int phase;
      logic [COUNT_W-1:0] count;
      start = bytes_sent;
      frames = 0;
      while (bytes_sent - start < RANDOM_BYTES) begin
         if (frames % FRAMES_PER_SETTING == 0) begin
            phase = frames / FRAMES_PER_SETTING;
            case (phase % 4)
               0: count = 3'd7;
               1: count = 3'd0;
               2: count = 3'd1;
               default: count = COUNT_W'($urandom_range(0, 7));
            endcase
            fill_random_calls();
            apply_config(count);
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
         end
         case ($urandom_range(0, 9))
            0: build_noise_frame($urandom_range(1, 6));
            1: build_frame($urandom_range(MAX_DIGIS + 1, MAX_DIGIS + 3), 1'b0, 1'b0,
                           $urandom_range(0, 3));
            2: build_frame($urandom_range(0, MAX_DIGIS), 1'b0, 1'b1, 0);
            3: build_frame($urandom_range(0, 2), 1'b1, 1'b0, $urandom_range(0, 3));
            default: build_frame($urandom_range(0, MAX_DIGIS), 1'b0, 1'b0,
                                 $urandom_range(0, 6));
         endcase
         send_frame();
         frames++;
      end
   endtask

   // ---------------------------------------------------------------- receiver and checks

   // Ready driver: long hold-off first, then the per-item stall, else ready.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Compare each accepted verdict with the oldest prediction.
   always @(posedge clock) begin : check_verdict
      verdict_item want_item;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         stall_left = recv_idle ? $urandom_range(0, 3) : 0;
         if (verdict_queue.size() == 0) begin
            $error("verdict with none pending: echo %0b verdict %0d",
                   rsp_ch.echo, rsp_ch.verdict);
            fail_count++;
         end else begin
            want_item = verdict_queue.pop_front();
            if (rsp_ch.echo !== want_item.echo) begin
               $error("echo: expected %0b, actual %0b", want_item.echo, rsp_ch.echo);
               fail_count++;
            end
            if (rsp_ch.verdict !== want_item.verdict) begin
               $error("verdict: expected %0d, actual %0d", want_item.verdict,
                      rsp_ch.verdict);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
          (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.frame_byte   = '0;
      req_ch.end_of_frame = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = '0;
      csr_ch.data         = '0;
      reset_filter_state();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed();
      test_digipeaters();
      test_pressure();
      test_random();
      wait_idle();

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
design/aef_pkg.sv
design/aef_channels.sv
design/aef_csr.sv
design/aef_parse.sv
design/aef_match.sv
design/ax25_echo_filter_unit.sv
dv/testbench.sv
